>>> src/ultrasonic_range_qualifier_core_macros.svh
// ----------------------------------------------------------------------------
// Ultrasonic range qualifier assertion macros
// Shared concurrent assertion shorthands; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_QUALIFIER_CORE_MACROS_SVH
`define ULTRASONIC_RANGE_QUALIFIER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Condition must never hold outside reset
`define URQ_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
// Antecedent implies consequent in the same cycle
`define URQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle
`define URQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define URQ_ASSERT_NEVER(label, clk, rst, cond, msg)
`define URQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define URQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> src/urq_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic range qualifier package
// Shared types, register map and the distance code function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urq_pkg;

   // Register map: index = paddr[4:2]
   localparam int unsigned CsrAddrW = 5;
   localparam logic [2:0] RegScale = 3'd0;
   localparam logic [2:0] RegMin   = 3'd1;
   localparam logic [2:0] RegMax   = 3'd2;
   localparam logic [2:0] RegJump  = 3'd3;
   localparam logic [2:0] RegLimit = 3'd4;

   // Register reset values
   localparam logic [15:0] ScaleReset = 16'd1141;
   localparam logic [9:0]  MinReset   = 10'd25;
   localparam logic [9:0]  MaxReset   = 10'd500;
   localparam logic [9:0]  JumpReset  = 10'd20;
   localparam logic [3:0]  LimitReset = 4'd5;

   // Distance code: d*CodeFull/CodeSpan, saturated
   localparam logic [9:0]  CodeFull  = 10'd1023;
   localparam logic [9:0]  CodeSpan  = 10'd500;
   // floor(y/500) == (y*CodeRecip) >> CodeShift for y below 59000
   localparam logic [15:0] CodeRecip = 16'd33555;
   localparam int unsigned CodeShift = 24;

   typedef struct packed {
      logic [15:0] scale;
      logic [9:0]  min_dist;
      logic [9:0]  max_dist;
      logic [9:0]  max_jump;
      logic [3:0]  err_limit;
   } cfg_type;

   // Queue entry between front and back
   typedef struct packed {
      logic [1:0] ch;
      logic       gate;
      logic [9:0] raw;
      logic [9:0] code;
   } fq_entry_type;

   // d*1023/500 = 2d + floor(23d/500), exact for d up to 500
   function automatic logic [9:0] code_of(input logic [9:0] d);
      logic [14:0] y;
      logic [30:0] prod;
      logic [10:0] c;
      y    = ({5'd0, d} << 4) + ({5'd0, d} << 3) - {5'd0, d};
      prod = 31'(y) * 31'(CodeRecip);
      c    = ({1'b0, d} << 1) + 11'(prod >> CodeShift);
      if (d > CodeSpan) begin
         return CodeFull;
      end
      return c[9:0];
   endfunction

endpackage

>>> src/urq_fifo.sv
// ----------------------------------------------------------------------------
// Ultrasonic range qualifier queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ultrasonic_range_qualifier_core_macros.svh"

module urq_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  urq_pkg::fq_entry_type din,
   input  logic                  pop,
   output urq_pkg::fq_entry_type dout,
   output logic                  full,
   output logic                  empty
);
   import urq_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   fq_entry_type        mem_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign full  = (count_ff == CntW'(DEPTH));
   assign empty = (count_ff == '0);
   assign dout  = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   `URQ_ASSERT_NEVER(a_push_full, clock, reset, push && full, "push into full queue")
   `URQ_ASSERT_NEVER(a_pop_empty, clock, reset, pop && empty, "pop from empty queue")
   `URQ_ASSERT_NEVER(a_count_range, clock, reset, count_ff > CntW'(DEPTH), "queue count overflow")

endmodule

>>> src/urq_front.sv
// ----------------------------------------------------------------------------
// Ultrasonic range qualifier front
// Accepts echo beats, scales them to centimetres, windows the result and
// precomputes the distance code for the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urq_front #(
   parameter int unsigned NUM_CHANNELS = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  urq_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_command,
   input  logic [14:0]           req_echo_us,
   input  logic                  req_gate_open,
   output logic                  push,
   output urq_pkg::fq_entry_type push_entry,
   input  logic                  q_full
);
   import urq_pkg::*;

   logic        adv;
   logic        take;

   logic        s1_vld_ff, s1_vld_in;
   logic [1:0]  s1_ch_ff;
   logic        s1_gate_ff;
   logic        s1_echo_nz_ff;
   logic [30:0] s1_prod_ff;

   logic        s2_vld_ff, s2_vld_in;
   logic [1:0]  s2_ch_ff;
   logic        s2_gate_ff;
   logic [9:0]  s2_raw_ff;

   logic [25:0] lo_bound;
   logic [25:0] hi_bound;
   logic [9:0]  raw_in;

   // Whole front moves together unless stage two holds a beat and the queue is full
   assign adv       = !(s2_vld_ff && q_full);
   assign req_stall = !adv;
   // Drop beats for channels that do not exist
   assign take      = req_valid && adv && (32'(req_command) < NUM_CHANNELS);

   assign s1_vld_in = adv ? take : s1_vld_ff;
   assign s2_vld_in = adv ? s1_vld_ff : s2_vld_ff;

   // Window the Q16 product and take the integer part
   assign lo_bound = {cfg.min_dist, 16'd0};
   assign hi_bound = {cfg.max_dist, 16'd0};
   always_comb begin
      raw_in = s1_prod_ff[25:16];
      if (!s1_echo_nz_ff || (s1_prod_ff < 31'(lo_bound)) ||
          (s1_prod_ff > 31'(hi_bound))) begin
         raw_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   // Stage one: multiply echo width by scale
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ch_ff      <= req_command;
         s1_gate_ff    <= req_gate_open;
         s1_echo_nz_ff <= (req_echo_us != '0);
         s1_prod_ff    <= 31'(req_echo_us) * 31'(cfg.scale);
      end
   end

   // Stage two: raw distance
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ch_ff   <= s1_ch_ff;
         s2_gate_ff <= s1_gate_ff;
         s2_raw_ff  <= raw_in;
      end
   end

   // Hand the beat to the queue with its code
   assign push            = s2_vld_ff && adv;
   assign push_entry.ch   = s2_ch_ff;
   assign push_entry.gate = s2_gate_ff;
   assign push_entry.raw  = s2_raw_ff;
   assign push_entry.code = code_of(s2_raw_ff);

endmodule

>>> src/urq_back.sv
// ----------------------------------------------------------------------------
// Ultrasonic range qualifier back
// Per-channel filter update and the registered result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ultrasonic_range_qualifier_core_macros.svh"

module urq_back #(
   parameter int unsigned NUM_CHANNELS = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  urq_pkg::cfg_type      cfg,
   input  urq_pkg::fq_entry_type entry,
   input  logic                  q_empty,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_channel,
   output logic [9:0]            rsp_distance_cm,
   output logic [9:0]            rsp_distance_code,
   output logic                  rsp_reading_accepted,
   output logic                  rsp_channel_cleared
);
   import urq_pkg::*;

   localparam int unsigned ChIdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic [9:0]        filt_ff [NUM_CHANNELS];
   logic [3:0]        err_ff  [NUM_CHANNELS];
   logic [9:0]        code_ff [NUM_CHANNELS];

   logic              rsp_vld_ff, rsp_vld_in;
   logic [1:0]        rsp_ch_ff;
   logic [9:0]        rsp_dist_ff;
   logic [9:0]        rsp_code_ff;
   logic              rsp_acc_ff;
   logic              rsp_clr_ff;

   logic [ChIdxW-1:0] idx;
   logic [9:0]        f_cur;
   logic [3:0]        e_cur;
   logic [9:0]        diff;
   logic [3:0]        e_inc;
   logic              bad;
   logic [9:0]        f_in;
   logic [3:0]        e_in;
   logic [9:0]        c_in;
   logic              acc_in;
   logic              clr_in;

   // Take the next beat when the result register is free or draining
   assign pop        = !q_empty && (!rsp_vld_ff || !rsp_stall);
   assign rsp_vld_in = pop || (rsp_vld_ff && rsp_stall);

   assign idx   = ChIdxW'(entry.ch);
   assign f_cur = filt_ff[idx];
   assign e_cur = err_ff[idx];
   assign diff  = (entry.raw > f_cur) ? entry.raw - f_cur : f_cur - entry.raw;
   assign e_inc = e_cur + 4'd1;

   // Qualify the reading against window and jump limit
   always_comb begin
      f_in   = f_cur;
      e_in   = e_cur;
      c_in   = code_ff[idx];
      acc_in = 1'b0;
      clr_in = 1'b0;
      bad    = 1'b0;
      if ((entry.ch != '0) && !entry.gate) begin
         // Closed gate on a channel other than 0: drop the distance, keep the error count
         f_in = '0;
         c_in = '0;
      end else begin
         if ((entry.raw >= cfg.min_dist) && (entry.raw <= cfg.max_dist)) begin
            bad = (f_cur != '0) && (diff > cfg.max_jump);
         end else begin
            bad = 1'b1;
         end
         if (!bad) begin
            f_in   = entry.raw;
            c_in   = entry.code;
            e_in   = '0;
            acc_in = 1'b1;
         end else if (e_inc >= cfg.err_limit) begin
            f_in   = '0;
            c_in   = '0;
            e_in   = '0;
            clr_in = 1'b1;
         end else begin
            e_in = e_inc;
         end
      end
   end

   // Channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            filt_ff[i] <= '0;
            err_ff[i]  <= '0;
            code_ff[i] <= '0;
         end
      end else if (pop) begin
         filt_ff[idx] <= f_in;
         err_ff[idx]  <= e_in;
         code_ff[idx] <= c_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ch_ff   <= entry.ch;
         rsp_dist_ff <= f_in;
         rsp_code_ff <= c_in;
         rsp_acc_ff  <= acc_in;
         rsp_clr_ff  <= clr_in;
      end
   end

   assign rsp_valid            = rsp_vld_ff;
   assign rsp_channel          = rsp_ch_ff;
   assign rsp_distance_cm      = rsp_dist_ff;
   assign rsp_distance_code    = rsp_code_ff;
   assign rsp_reading_accepted = rsp_acc_ff;
   assign rsp_channel_cleared  = rsp_clr_ff;

   `URQ_ASSERT_NEVER(a_acc_and_clr, clock, reset, rsp_vld_ff && rsp_acc_ff && rsp_clr_ff, "accepted and cleared together")
   `URQ_ASSERT_IMPLY(a_clr_zero, clock, reset, rsp_vld_ff && rsp_clr_ff, (rsp_dist_ff == '0) && (rsp_code_ff == '0), "cleared beat carries a distance")
   `URQ_ASSERT_NEXT(a_pop_shows, clock, reset, pop, rsp_vld_ff, "popped beat not presented")

endmodule

>>> src/ultrasonic_range_qualifier_core.sv
// ----------------------------------------------------------------------------
// Ultrasonic range qualifier core
// Converts echo widths to filtered per-channel distances and distance codes.
// ----------------------------------------------------------------------------
// Path: an accepted request beat passes two front stages (multiply and
//   window), one queue slot and one result register to its result beat.
// Throughput: one beat per cycle unless rsp_stall or a full queue holds it
//   up; the back updates channel state in the cycle the beat leaves the queue.
// Reset: synchronous; clears filtered distances, error counts, queue and
//   valids, and loads the register reset values.
`timescale 1ns / 1ps

module ultrasonic_range_qualifier_core #(
   parameter int unsigned NUM_CHANNELS = 3,
   parameter int unsigned QUEUE_DEPTH  = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic [14:0]                   req_echo_us,
   input  logic                          req_gate_open,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_channel,
   output logic [9:0]                    rsp_distance_cm,
   output logic [9:0]                    rsp_distance_code,
   output logic                          rsp_reading_accepted,
   output logic                          rsp_channel_cleared,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [urq_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import urq_pkg::*;

   cfg_type      cfg_ff;
   logic         csr_wr;
   logic [2:0]   reg_idx;
   logic         q_push;
   logic         q_pop;
   logic         q_full;
   logic         q_empty;
   fq_entry_type q_din;
   fq_entry_type q_dout;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CsrAddrW-1:2];

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale     <= ScaleReset;
         cfg_ff.min_dist  <= MinReset;
         cfg_ff.max_dist  <= MaxReset;
         cfg_ff.max_jump  <= JumpReset;
         cfg_ff.err_limit <= LimitReset;
      end else if (csr_wr) begin
         unique case (reg_idx)
            RegScale: cfg_ff.scale     <= csr_pwdata[15:0];
            RegMin:   cfg_ff.min_dist  <= csr_pwdata[9:0];
            RegMax:   cfg_ff.max_dist  <= csr_pwdata[9:0];
            RegJump:  cfg_ff.max_jump  <= csr_pwdata[9:0];
            RegLimit: cfg_ff.err_limit <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (reg_idx)
         RegScale: csr_prdata = {16'd0, cfg_ff.scale};
         RegMin:   csr_prdata = {22'd0, cfg_ff.min_dist};
         RegMax:   csr_prdata = {22'd0, cfg_ff.max_dist};
         RegJump:  csr_prdata = {22'd0, cfg_ff.max_jump};
         RegLimit: csr_prdata = {28'd0, cfg_ff.err_limit};
         default:  csr_prdata = '0;
      endcase
   end

   urq_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_echo_us   (req_echo_us),
      .req_gate_open (req_gate_open),
      .push          (q_push),
      .push_entry    (q_din),
      .q_full        (q_full)
   );

   urq_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .full  (q_full),
      .empty (q_empty)
   );

   urq_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .entry                (q_dout),
      .q_empty              (q_empty),
      .pop                  (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_channel          (rsp_channel),
      .rsp_distance_cm      (rsp_distance_cm),
      .rsp_distance_code    (rsp_distance_code),
      .rsp_reading_accepted (rsp_reading_accepted),
      .rsp_channel_cleared  (rsp_channel_cleared)
   );

endmodule
